// ----- hdl/fet_pkg.sv -----
// ----------------------------------------------------------------------------
// Fractal escape-time package
// Shared constants, register indexes and sequencer states for the
// escape-time iteration block.
// ----------------------------------------------------------------------------
package fet_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int FRAC_BITS      = 28;
  localparam int COUNT_WIDTH    = 16;
  localparam int MAX_ITER_RESET = 256;

  localparam int REG_INDEX_WIDTH = 2;

  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_MAX_ITER   = 2'd0,
    REG_JULIA_MODE = 2'd1,
    REG_JULIA_C_RE = 2'd2,
    REG_JULIA_C_IM = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_TEST,
    ST_CROSS,
    ST_UPDATE
  } state_t;

endpackage

// ----- hdl/fet_mul.sv -----
// ----------------------------------------------------------------------------
// Shared signed multiplier
// Full-precision signed product with a registered result; the product is
// loaded only when enabled and holds otherwise.
// ----------------------------------------------------------------------------
module fet_mul #(
  parameter int WIDTH = fet_pkg::COORD_WIDTH
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [WIDTH-1:0]   a,
  input  logic signed [WIDTH-1:0]   b,
  output logic signed [2*WIDTH-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

// ----- hdl/fractal_escape_time_unit.sv -----
// ----------------------------------------------------------------------------
// Fractal escape-time unit
// Iterates z = z*z + c on one fixed-point point at a time and reports the
// iteration at which |z|^2 first exceeds four.
// ----------------------------------------------------------------------------
// Usage:
//   A request on point_re/point_im is taken when in_valid and in_ready are
//   both high; in_ready is high only while the sequencer is idle. Points are
//   signed with FRAC_BITS fraction bits. In Mandelbrot mode c is the point,
//   in Julia mode c is the configured constant and iteration zero is never
//   tested for escape.
//   Sequencing: the shared multiplier runs three products per iteration. After
//   acceptance each pass steps through the two square states and the test,
//   cross and update states; the first pass only forms the first update of z,
//   and each later test checks one iteration index. A point that never escapes
//   gives no result. With max_iterations of zero the request is taken and
//   dropped at once.
//   The result sits in an output register; the next point may start while it
//   waits. If a second escape is found while the first is still not taken,
//   the sequencer holds until out_ready frees the register.
//   Reset clears the sequencer and output valid and restores the registers
//   to a limit of 256, Mandelbrot mode and a zero Julia constant.
// ----------------------------------------------------------------------------
module fractal_escape_time_unit #(
  parameter int COORD_WIDTH = fet_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = fet_pkg::FRAC_BITS,
  parameter int COUNT_WIDTH = fet_pkg::COUNT_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [fet_pkg::REG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [(COORD_WIDTH > COUNT_WIDTH ? COORD_WIDTH : COUNT_WIDTH)-1:0] cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [COORD_WIDTH-1:0]           point_re,
  input  logic signed [COORD_WIDTH-1:0]           point_im,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [COORD_WIDTH-1:0]           out_re,
  output logic signed [COORD_WIDTH-1:0]           out_im,
  output logic [COUNT_WIDTH-1:0]                  escape_index
);

  localparam int W     = COORD_WIDTH;
  localparam int MAG_W = (2*W+1 > 2*FRAC_BITS+3) ? 2*W+1 : 2*FRAC_BITS+3;
  localparam logic [MAG_W-1:0] FOUR = {{(MAG_W-1){1'b0}}, 1'b1} << (2*FRAC_BITS+2);

  // Configuration registers.
  logic [COUNT_WIDTH-1:0] max_iterations;
  logic                   julia_mode;
  logic signed [W-1:0]    julia_c_re;
  logic signed [W-1:0]    julia_c_im;

  fet_pkg::state_t state, state_next;

  logic signed [W-1:0]     pre, pim, zre, zim;
  logic signed [2*W-1:0]   rr, ii;
  logic signed [2*W:0]     diff;
  logic [COUNT_WIDTH-1:0]  it;
  logic                    primed;

  logic                    mul_en;
  logic signed [W-1:0]     mul_a, mul_b;
  logic signed [2*W-1:0]   prod;

  logic                    accept, load_out, escape, last;
  logic [COUNT_WIDTH:0]    it_plus;
  logic [MAG_W-1:0]        mag;
  logic signed [W-1:0]     cre, cim;
  logic signed [2*W:0]     diff_sh;
  logic signed [2*W+1:0]   sum_re;
  logic signed [2*W-1:0]   ri_sh;
  logic signed [2*W:0]     sum_im;
  logic signed [W-1:0]     sat_re, sat_im;

  fet_mul #(
    .WIDTH(W)
  ) u_mul (
    .clk(clk),
    .en (mul_en),
    .a  (mul_a),
    .b  (mul_b),
    .p  (prod)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= COUNT_WIDTH'(fet_pkg::MAX_ITER_RESET);
      julia_mode     <= 1'b0;
      julia_c_re     <= '0;
      julia_c_im     <= '0;
    end else if (cfg_we) begin
      case (fet_pkg::reg_index_t'(cfg_index))
        fet_pkg::REG_MAX_ITER:   max_iterations <= cfg_data[COUNT_WIDTH-1:0];
        fet_pkg::REG_JULIA_MODE: julia_mode     <= cfg_data[0];
        fet_pkg::REG_JULIA_C_RE: julia_c_re     <= cfg_data[W-1:0];
        fet_pkg::REG_JULIA_C_IM: julia_c_im     <= cfg_data[W-1:0];
        default: ;
      endcase
    end
  end

  assign cre = julia_mode ? julia_c_re : pre;
  assign cim = julia_mode ? julia_c_im : pim;

  // The escape test uses the fresh square of the imaginary part straight
  // from the multiplier, since ii is loaded in the same cycle.
  assign mag     = MAG_W'($unsigned(rr)) + MAG_W'($unsigned(prod));
  assign escape  = primed && (mag > FOUR) && !(julia_mode && (it == '0));
  assign it_plus = {1'b0, it} + 1'b1;
  assign last    = (it_plus == {1'b0, max_iterations});

  // Next z, each part floored and clamped to the coordinate range.
  assign diff_sh = diff >>> FRAC_BITS;
  assign sum_re  = {diff_sh[2*W], diff_sh} + {{(W+2){cre[W-1]}}, cre};
  assign ri_sh   = prod >>> (FRAC_BITS - 1);
  assign sum_im  = {ri_sh[2*W-1], ri_sh} + {{(W+1){cim[W-1]}}, cim};

  always_comb begin
    if (sum_re[2*W+1:W-1] == {(W+3){sum_re[2*W+1]}}) begin
      sat_re = sum_re[W-1:0];
    end else begin
      sat_re = {sum_re[2*W+1], {(W-1){~sum_re[2*W+1]}}};
    end
    if (sum_im[2*W:W-1] == {(W+2){sum_im[2*W]}}) begin
      sat_im = sum_im[W-1:0];
    end else begin
      sat_im = {sum_im[2*W], {(W-1){~sum_im[2*W]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fet_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    accept     = 1'b0;
    load_out   = 1'b0;
    mul_en     = 1'b0;
    mul_a      = zre;
    mul_b      = zre;
    case (state)
      fet_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          accept = 1'b1;
          if (max_iterations != '0) begin
            state_next = fet_pkg::ST_SQ_RE;
          end
        end
      end
      fet_pkg::ST_SQ_RE: begin
        mul_en     = 1'b1;
        state_next = fet_pkg::ST_SQ_IM;
      end
      fet_pkg::ST_SQ_IM: begin
        mul_en     = 1'b1;
        mul_a      = zim;
        mul_b      = zim;
        state_next = fet_pkg::ST_TEST;
      end
      fet_pkg::ST_TEST: begin
        if (escape) begin
          if (!out_valid || out_ready) begin
            load_out   = 1'b1;
            state_next = fet_pkg::ST_IDLE;
          end
        end else if (primed && last) begin
          state_next = fet_pkg::ST_IDLE;
        end else begin
          state_next = fet_pkg::ST_CROSS;
        end
      end
      fet_pkg::ST_CROSS: begin
        mul_en     = 1'b1;
        mul_a      = zre;
        mul_b      = zim;
        state_next = fet_pkg::ST_UPDATE;
      end
      fet_pkg::ST_UPDATE: begin
        state_next = fet_pkg::ST_SQ_RE;
      end
      default: begin
        state_next = fet_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      it     <= '0;
      primed <= 1'b0;
    end else if (accept) begin
      it     <= '0;
      primed <= 1'b0;
    end else if (state == fet_pkg::ST_UPDATE) begin
      primed <= 1'b1;
    end else if (state == fet_pkg::ST_TEST && primed && !escape && !last) begin
      it <= it_plus[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pre <= point_re;
      pim <= point_im;
      zre <= point_re;
      zim <= point_im;
    end
    if (state == fet_pkg::ST_SQ_IM) begin
      rr <= prod;
    end
    if (state == fet_pkg::ST_TEST) begin
      ii <= prod;
    end
    if (state == fet_pkg::ST_CROSS) begin
      diff <= {rr[2*W-1], rr} - {ii[2*W-1], ii};
    end
    if (state == fet_pkg::ST_UPDATE) begin
      zre <= sat_re;
      zim <= sat_im;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_re       <= pre;
      out_im       <= pim;
      escape_index <= it;
    end
  end

  a_index_below_limit: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (escape_index < max_iterations))
    else $error("escape index at or beyond the iteration limit");

  a_julia_skips_first: assert property (@(posedge clk) disable iff (rst)
    load_out |=> !(julia_mode && (escape_index == '0)))
    else $error("Julia point escaped on iteration zero");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != fet_pkg::ST_IDLE) |-> (it < max_iterations))
    else $error("iteration counter ran past the limit");

  a_no_escape_before_update: assert property (@(posedge clk) disable iff (rst)
    (state == fet_pkg::ST_TEST && !primed) |-> !load_out)
    else $error("result loaded before the first update of z");

endmodule
